/* src/bswa_pkg.sv */
// ----------------------------------------------------------------------------
// bswa_pkg - shared types and constants for the bit sync word aligner
// Byte window layout, register indexes and the state/result records passed
// between the top level and the alignment core.
// ----------------------------------------------------------------------------
package bswa_pkg;

   localparam int MAX_PATTERN_BYTES = 8;
   localparam int WIN_BYTES         = MAX_PATTERN_BYTES + 1;
   localparam int BYTE_W            = 8;
   localparam int OFS_W             = 3;
   localparam int PATTERN_W         = MAX_PATTERN_BYTES * BYTE_W;
   localparam int LEN_W             = 4;
   localparam int CSR_IDX_W         = 2;
   localparam int CSR_DATA_W        = PATTERN_W;

   localparam logic [LEN_W-1:0] PATTERN_BYTES_RESET = LEN_W'(3);

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_WORD  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_BYTES = CSR_IDX_W'(1);

   // byte 0 is the oldest byte of the window
   typedef logic [WIN_BYTES-1:0][BYTE_W-1:0] window_type;

   typedef struct packed {
      window_type       window;
      logic             started;
      logic             locked;
      logic [OFS_W-1:0] lock_offset;
   } state_type;

   typedef struct packed {
      logic              emit;
      logic [BYTE_W-1:0] aligned_byte;
      logic [OFS_W-1:0]  bit_offset;
      state_type         state_nx;
   } core_out_type;

endpackage

/* src/bit_sync_word_aligner_unit.sv */
// ----------------------------------------------------------------------------
// bit_sync_word_aligner_unit - sync word search and byte realignment
// Feed received bytes MSB first on req_; leading zero bytes are dropped. Once
// the pattern (pattern_word, pattern_bytes long, first byte most significant)
// is seen at some bit offset, that offset is locked for good and every later
// request yields one rsp_ byte realigned to it, starting with the pattern's
// first byte, along with the offset. Requests before the lock yield nothing.
// One request per cycle sustained while results are taken; a request passes
// through the input register, then the parallel eight-offset compare into
// the result register. A stalled result holds the input register, so
// intake stops once one request waits behind it; requests that yield nothing
// also wait for the result register to move. Write csr_ registers only while
// the unit is idle.
// ----------------------------------------------------------------------------
module bit_sync_word_aligner_unit import bswa_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [BYTE_W-1:0]     req_data_byte,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [BYTE_W-1:0]     rsp_aligned_byte,
   output logic [OFS_W-1:0]      rsp_bit_offset,
   // configuration
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   logic [PATTERN_W-1:0] pattern_word_ff;
   logic [LEN_W-1:0]     pattern_bytes_ff;

   state_type            state_ff;

   // input register
   logic                 s1_valid_ff, s1_valid_in;
   logic [BYTE_W-1:0]    s1_byte_ff;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]    rsp_aligned_byte_ff;
   logic [OFS_W-1:0]     rsp_bit_offset_ff;

   core_out_type         core_out;
   logic                 out_free;
   logic                 s1_advance;
   logic                 req_take;

   // config writes; unknown indexes are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_word_ff  <= '0;
         pattern_bytes_ff <= PATTERN_BYTES_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_PATTERN_WORD:  pattern_word_ff  <= csr_write_data;
            CSR_PATTERN_BYTES: pattern_bytes_ff <= csr_write_data[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   bswa_align_core u_core (
      .data_byte     (s1_byte_ff),
      .pattern_word  (pattern_word_ff),
      .pattern_bytes (pattern_bytes_ff),
      .state         (state_ff),
      .result        (core_out)
   );

   // result slot frees up when empty or being taken this cycle
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign s1_advance = s1_valid_ff && out_free;
   assign req_ready  = !s1_valid_ff || out_free;
   assign req_take   = req_valid && req_ready;

   assign s1_valid_in  = req_take || (s1_valid_ff && !s1_advance);
   assign rsp_valid_in = s1_advance ? core_out.emit : (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_advance) begin
            state_ff <= core_out.state_nx;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_byte_ff <= req_data_byte;
      end
      if (s1_advance && core_out.emit) begin
         rsp_aligned_byte_ff <= core_out.aligned_byte;
         rsp_bit_offset_ff   <= core_out.bit_offset;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_aligned_byte = rsp_aligned_byte_ff;
   assign rsp_bit_offset   = rsp_bit_offset_ff;

endmodule

/* src/bswa_align_core.sv */
// ----------------------------------------------------------------------------
// bswa_align_core - per-byte window update, sync search and realignment
// Loads one byte into the window, compares all eight bit alignments against
// the pattern in parallel, and produces the next state and the result byte.
// ----------------------------------------------------------------------------
module bswa_align_core import bswa_pkg::*; (
   input  logic [BYTE_W-1:0]    data_byte,
   input  logic [PATTERN_W-1:0] pattern_word,
   input  logic [LEN_W-1:0]     pattern_bytes,
   input  state_type            state,
   output core_out_type         result
);

   logic [LEN_W-1:0]     p_len;
   logic [OFS_W-1:0]     pat_shift;
   logic [PATTERN_W-1:0] pat_aligned;
   window_type           win_in;
   window_type           win_nx;
   logic                 started_nx;
   logic [7:0]           match;
   logic                 any_hit;
   logic [OFS_W-1:0]     hit_ofs;
   logic [OFS_W-1:0]     use_ofs;
   logic [2*BYTE_W-1:0]  out_pair;

   // clamp length to 1..MAX_PATTERN_BYTES
   always_comb begin
      if (pattern_bytes == '0) begin
         p_len = LEN_W'(1);
      end else if (pattern_bytes > LEN_W'(MAX_PATTERN_BYTES)) begin
         p_len = LEN_W'(MAX_PATTERN_BYTES);
      end else begin
         p_len = pattern_bytes;
      end
   end

   // move the used pattern bytes to the top so pattern byte k sits at slot k
   assign pat_shift   = OFS_W'(LEN_W'(MAX_PATTERN_BYTES) - p_len);
   assign pat_aligned = pattern_word << {pat_shift, 3'b000};

   always_comb begin
      win_in        = state.window;
      win_in[p_len] = data_byte;
   end

   assign started_nx = state.started | (data_byte != '0);

   // all eight alignments in parallel
   always_comb begin
      logic [2*BYTE_W-1:0] pair;
      logic [BYTE_W-1:0]   want;
      for (int i = 0; i < 8; i++) begin
         match[i] = 1'b1;
         for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
            pair = {win_in[k], win_in[k+1]} << i;
            want = pat_aligned[BYTE_W*(MAX_PATTERN_BYTES-1-k) +: BYTE_W];
            if ((LEN_W'(k) < p_len) && (pair[2*BYTE_W-1:BYTE_W] != want)) begin
               match[i] = 1'b0;
            end
         end
      end
   end

   // earliest alignment wins
   always_comb begin
      hit_ofs = '0;
      for (int i = 7; i >= 0; i--) begin
         if (match[i]) begin
            hit_ofs = OFS_W'(i);
         end
      end
   end

   assign any_hit = |match;
   assign use_ofs = state.locked ? state.lock_offset : hit_ofs;
   assign out_pair = {win_in[0], win_in[1]} << use_ofs;

   // a full byte passes through bytes 0..P: each moves down one, last clears
   always_comb begin
      win_nx = win_in;
      if (started_nx) begin
         for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
            if (LEN_W'(k) < p_len) begin
               win_nx[k] = win_in[k+1];
            end else if (LEN_W'(k) == p_len) begin
               win_nx[k] = '0;
            end
         end
         if (p_len == LEN_W'(MAX_PATTERN_BYTES)) begin
            win_nx[MAX_PATTERN_BYTES] = '0;
         end
      end
   end

   always_comb begin
      result.emit                 = started_nx & (state.locked | any_hit);
      result.aligned_byte         = out_pair[2*BYTE_W-1:BYTE_W];
      result.bit_offset           = use_ofs;
      result.state_nx.window      = win_nx;
      result.state_nx.started     = started_nx;
      result.state_nx.locked      = state.locked | (started_nx & any_hit);
      result.state_nx.lock_offset = state.lock_offset;
      if (started_nx && !state.locked && any_hit) begin
         result.state_nx.lock_offset = hit_ofs;
      end
   end

endmodule
